// File: rtl/core/macd_pkg.sv
// Shared types, constants and helpers for the MACD crossover filter.
`timescale 1ns / 1ps

package macd_pkg;

  localparam int DATA_W   = 24;
  localparam int W_FRAC   = 18;
  localparam int WEIGHT_W = 18;
  localparam int MUL_A_W  = DATA_W + 1;
  localparam int MUL_B_W  = WEIGHT_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int ACC_W    = 45;
  localparam int AVG_W    = ACC_W - W_FRAC;
  localparam int DIFF_W   = AVG_W + 1;

  typedef enum logic [1:0] {
    WIN_FAST,
    WIN_SLOW,
    WIN_SIG
  } win_e;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_BUY  = 2'd1,
    EV_SELL = 2'd2
  } event_e;

  typedef struct packed {
    logic start;
    logic issue;
    win_e win;
    logic acc_clr;
    logic fin_fast;
    logic fin_slow;
    logic fin_sig;
    logic sig_valid;
    logic out_load;
  } macd_cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
  } macd_status_t;

  function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [DIFF_W-1:0] v);
    logic [DIFF_W-DATA_W:0] top;
    top = v[DIFF_W-1:DATA_W-1];
    if (top == '0 || top == '1) begin
      return v[DATA_W-1:0];
    end else if (v[DIFF_W-1]) begin
      return {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      return {1'b0, {(DATA_W-1){1'b1}}};
    end
  endfunction

endpackage

// File: rtl/core/macd_if.sv
// Valid/ready channel interfaces for price input and MACD result words.
`timescale 1ns / 1ps

interface macd_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] price;

  modport source (output valid, output price, input ready);
  modport sink (input valid, input price, output ready);
endinterface

interface macd_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] macd;
  logic signed [23:0] signal;
  logic               signal_valid;
  logic [1:0]         event_res;

  modport source (output valid, output macd, output signal, output signal_valid,
                  output event_res, input ready);
  modport sink (input valid, input macd, input signal, input signal_valid,
                input event_res, output ready);
endinterface

// File: rtl/core/macd_crossover_filter.sv
// Top level of the MACD crossover filter: sequencer plus datapath.
//
//   channel  dir  word                                      handshake
//   in_i     in   price (24b unsigned Q16.8)                valid/ready
//   out_o    out  macd, signal, signal_valid, event_res     valid/ready
//
// Warm-up words (before sample HIST_DEPTH) give no result. Later words run the fast,
// slow and signal windows, the signal window only once the signal line fills;
// one shared multiply-accumulate pipeline walks every tap of each window in turn.
// The result register lets the next word be taken while a result waits on out_o.
// Reset clears counters and previous MACD/signal values; history heads go to their last slot.
`timescale 1ns / 1ps

module macd_crossover_filter #(
  parameter int FAST_TAPS   = 13,
  parameter int SLOW_TAPS   = 27,
  parameter int SIGNAL_TAPS = 10,
  parameter int PRICE_BITS  = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  macd_in_if.sink           in_i,
  macd_out_if.source        out_o
);
  import macd_pkg::*;

  localparam int HIST_DEPTH = (FAST_TAPS > SLOW_TAPS) ? FAST_TAPS : SLOW_TAPS;
  localparam int MAX_TAPS   = (HIST_DEPTH > SIGNAL_TAPS) ? HIST_DEPTH : SIGNAL_TAPS;
  localparam int TAP_W      = $clog2(MAX_TAPS);

  macd_cmd_t        cmd;
  macd_status_t     status;
  logic [TAP_W-1:0] tap;

  macd_ctrl #(
    .FAST_TAPS   (FAST_TAPS),
    .SLOW_TAPS   (SLOW_TAPS),
    .SIGNAL_TAPS (SIGNAL_TAPS),
    .TAP_W       (TAP_W)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd),
    .tap_o      (tap)
  );

  macd_datapath #(
    .FAST_TAPS   (FAST_TAPS),
    .SLOW_TAPS   (SLOW_TAPS),
    .SIGNAL_TAPS (SIGNAL_TAPS),
    .PRICE_BITS  (PRICE_BITS),
    .TAP_W       (TAP_W)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .tap_i          (tap),
    .price_i        (in_i.price),
    .out_ready_i    (out_o.ready),
    .status_o       (status),
    .out_valid_o    (out_o.valid),
    .macd_o         (out_o.macd),
    .signal_o       (out_o.signal),
    .signal_valid_o (out_o.signal_valid),
    .event_o        (out_o.event_res)
  );

endmodule

// File: rtl/core/macd_coef_rom.sv
// Constant Q0.18 weight table of one truncated exponential window.
`timescale 1ns / 1ps

module macd_coef_rom #(
  parameter int TAPS = 13
) (
  input  logic [$clog2(TAPS)-1:0]        addr_i,
  output logic [macd_pkg::WEIGHT_W-1:0]  weight_o
);
  import macd_pkg::*;

  localparam int AW = $clog2(TAPS);
  localparam logic [63:0] MUL      = 64'(TAPS - 1);
  localparam logic [63:0] HALF_DEN = 64'((TAPS + 1) / 2);
  localparam logic [63:0] DEN      = 64'(TAPS + 1);
  localparam logic [63:0] P_ZERO   = 64'd1 << 40;

  function automatic logic [63:0] tap_sum();
    logic [63:0] p;
    logic [63:0] s;
    p = P_ZERO;
    s = '0;
    for (int i = 0; i < TAPS; i++) begin
      s = s + p;
      p = (p * MUL + HALF_DEN) / DEN;
    end
    return s;
  endfunction

  localparam logic [63:0] P_SUM    = tap_sum();
  localparam logic [63:0] HALF_SUM = P_SUM / 2;

  function automatic logic [TAPS*WEIGHT_W-1:0] make_table();
    logic [TAPS*WEIGHT_W-1:0] t;
    logic [63:0]              p;
    t = '0;
    p = P_ZERO;
    for (int i = 0; i < TAPS; i++) begin
      t[i*WEIGHT_W +: WEIGHT_W] = WEIGHT_W'(((p << W_FRAC) + HALF_SUM) / P_SUM);
      p = (p * MUL + HALF_DEN) / DEN;
    end
    return t;
  endfunction

  localparam logic [TAPS*WEIGHT_W-1:0] TABLE = make_table();

  always_comb begin
    if ({1'b0, addr_i} < (AW + 1)'(TAPS)) begin
      weight_o = TABLE[addr_i*WEIGHT_W +: WEIGHT_W];
    end else begin
      weight_o = '0;
    end
  end

endmodule

// File: rtl/core/macd_ctrl.sv
// Sequencer: sample counting, tap issue per window, finish and output steps.
`timescale 1ns / 1ps

module macd_ctrl #(
  parameter int FAST_TAPS   = 13,
  parameter int SLOW_TAPS   = 27,
  parameter int SIGNAL_TAPS = 10,
  parameter int TAP_W       = 5
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  macd_pkg::macd_status_t  status_i,
  output macd_pkg::macd_cmd_t     cmd_o,
  output logic [TAP_W-1:0]        tap_o
);
  import macd_pkg::*;

  localparam int HIST_DEPTH = (FAST_TAPS > SLOW_TAPS) ? FAST_TAPS : SLOW_TAPS;
  localparam int MACD_START = HIST_DEPTH - 1;
  localparam int SIG_START  = HIST_DEPTH + SIGNAL_TAPS - 2;
  localparam int CNT_W      = $clog2(SIG_START + 1);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_FAST_RUN  = 4'd1;
  localparam logic [3:0] S_FAST_WAIT = 4'd2;
  localparam logic [3:0] S_FAST_FIN  = 4'd3;
  localparam logic [3:0] S_SLOW_RUN  = 4'd4;
  localparam logic [3:0] S_SLOW_WAIT = 4'd5;
  localparam logic [3:0] S_SLOW_FIN  = 4'd6;
  localparam logic [3:0] S_SIG_RUN   = 4'd7;
  localparam logic [3:0] S_SIG_WAIT  = 4'd8;
  localparam logic [3:0] S_SIG_FIN   = 4'd9;
  localparam logic [3:0] S_OUT       = 4'd10;

  logic [3:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [TAP_W-1:0] tap_q, tap_d;
  logic             sig_due_q, sig_due_d;

  assign tap_o = tap_q;

  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    tap_d      = tap_q;
    sig_due_d  = sig_due_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.win  = WIN_FAST;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start   = 1'b1;
          cmd_o.acc_clr = 1'b1;
          tap_d         = '0;
          sig_due_d     = (count_q >= CNT_W'(SIG_START));
          if (count_q < CNT_W'(SIG_START)) begin
            count_d = count_q + CNT_W'(1);
          end
          if (count_q >= CNT_W'(MACD_START)) begin
            state_d = S_FAST_RUN;
          end
        end
      end
      S_FAST_RUN: begin
        cmd_o.issue = 1'b1;
        if (tap_q == TAP_W'(FAST_TAPS - 1)) begin
          tap_d   = '0;
          state_d = S_FAST_WAIT;
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      S_FAST_WAIT: begin
        if (!status_i.busy) begin
          state_d = S_FAST_FIN;
        end
      end
      S_FAST_FIN: begin
        cmd_o.fin_fast = 1'b1;
        cmd_o.acc_clr  = 1'b1;
        state_d        = S_SLOW_RUN;
      end
      S_SLOW_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.win   = WIN_SLOW;
        if (tap_q == TAP_W'(SLOW_TAPS - 1)) begin
          tap_d   = '0;
          state_d = S_SLOW_WAIT;
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      S_SLOW_WAIT: begin
        cmd_o.win = WIN_SLOW;
        if (!status_i.busy) begin
          state_d = S_SLOW_FIN;
        end
      end
      S_SLOW_FIN: begin
        cmd_o.win      = WIN_SLOW;
        cmd_o.fin_slow = 1'b1;
        cmd_o.acc_clr  = 1'b1;
        state_d        = sig_due_q ? S_SIG_RUN : S_SIG_FIN;
      end
      S_SIG_RUN: begin
        cmd_o.issue = 1'b1;
        cmd_o.win   = WIN_SIG;
        if (tap_q == TAP_W'(SIGNAL_TAPS - 1)) begin
          tap_d   = '0;
          state_d = S_SIG_WAIT;
        end else begin
          tap_d = tap_q + TAP_W'(1);
        end
      end
      S_SIG_WAIT: begin
        cmd_o.win = WIN_SIG;
        if (!status_i.busy) begin
          state_d = S_SIG_FIN;
        end
      end
      S_SIG_FIN: begin
        cmd_o.win       = WIN_SIG;
        cmd_o.fin_sig   = 1'b1;
        cmd_o.sig_valid = sig_due_q;
        cmd_o.acc_clr   = 1'b1;
        state_d         = S_OUT;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      tap_q     <= '0;
      sig_due_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      tap_q     <= tap_d;
      sig_due_q <= sig_due_d;
    end
  end

endmodule

// File: rtl/core/macd_datapath.sv
// Histories, shared multiply-accumulate, rounding, saturation and result register.
`timescale 1ns / 1ps

module macd_datapath #(
  parameter int FAST_TAPS   = 13,
  parameter int SLOW_TAPS   = 27,
  parameter int SIGNAL_TAPS = 10,
  parameter int PRICE_BITS  = 24,
  parameter int TAP_W       = 5
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  macd_pkg::macd_cmd_t                cmd_i,
  input  logic [TAP_W-1:0]                   tap_i,
  input  logic [macd_pkg::DATA_W-1:0]        price_i,
  input  logic                               out_ready_i,
  output macd_pkg::macd_status_t             status_o,
  output logic                               out_valid_o,
  output logic signed [macd_pkg::DATA_W-1:0] macd_o,
  output logic signed [macd_pkg::DATA_W-1:0] signal_o,
  output logic                               signal_valid_o,
  output logic [1:0]                         event_o
);
  import macd_pkg::*;

  localparam int HIST_DEPTH = (FAST_TAPS > SLOW_TAPS) ? FAST_TAPS : SLOW_TAPS;
  localparam int PW   = (PRICE_BITS < DATA_W) ? PRICE_BITS : DATA_W;
  localparam int PH_W = $clog2(HIST_DEPTH);
  localparam int MH_W = $clog2(SIGNAL_TAPS);
  localparam int FW   = $clog2(FAST_TAPS);
  localparam int SW   = $clog2(SLOW_TAPS);
  localparam int GW   = $clog2(SIGNAL_TAPS);
  localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(64'd1 << (W_FRAC - 1));

  logic [PW-1:0]            price_mem [HIST_DEPTH];
  logic signed [DATA_W-1:0] macd_mem [SIGNAL_TAPS];

  logic [PH_W-1:0] ph_head_q, ph_next, prd_ptr_q;
  logic [MH_W-1:0] mh_head_q, mh_next, mrd_ptr_q;

  logic [PW-1:0]            price_rd_q;
  logic signed [DATA_W-1:0] macd_rd_q;
  logic [WEIGHT_W-1:0]      w_fast, w_slow, w_sig, weight_d, w1_q;
  win_e                     win1_q;
  logic                     v1_q, v2_q;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_d, prod_q;
  logic signed [ACC_W-1:0]   acc_q, acc_rnd;
  logic signed [AVG_W-1:0]   avg_d, fast_avg_q;
  logic signed [DIFF_W-1:0]  diff_d;
  logic signed [DATA_W-1:0]  macd_sat, macd_q, sig_q, prev_macd_q, prev_sig_q;
  logic                      sig_valid_q;
  event_e                    event_d, event_q;

  macd_coef_rom #(.TAPS(FAST_TAPS)) u_rom_fast (
    .addr_i   (tap_i[FW-1:0]),
    .weight_o (w_fast)
  );

  macd_coef_rom #(.TAPS(SLOW_TAPS)) u_rom_slow (
    .addr_i   (tap_i[SW-1:0]),
    .weight_o (w_slow)
  );

  macd_coef_rom #(.TAPS(SIGNAL_TAPS)) u_rom_sig (
    .addr_i   (tap_i[GW-1:0]),
    .weight_o (w_sig)
  );

  always_comb begin
    case (cmd_i.win)
      WIN_FAST: weight_d = w_fast;
      WIN_SLOW: weight_d = w_slow;
      default:  weight_d = w_sig;
    endcase
  end

  assign ph_next = (ph_head_q == PH_W'(HIST_DEPTH - 1)) ? '0 : ph_head_q + PH_W'(1);
  assign mh_next = (mh_head_q == MH_W'(SIGNAL_TAPS - 1)) ? '0 : mh_head_q + MH_W'(1);

  // history memories, registered reads
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      price_mem[ph_next] <= price_i[PW-1:0];
    end
    if (cmd_i.issue) begin
      price_rd_q <= price_mem[prd_ptr_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_slow) begin
      macd_mem[mh_next] <= macd_sat;
    end
    if (cmd_i.issue) begin
      macd_rd_q <= macd_mem[mrd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_head_q <= PH_W'(HIST_DEPTH - 1);
      mh_head_q <= MH_W'(SIGNAL_TAPS - 1);
      prd_ptr_q <= '0;
      mrd_ptr_q <= '0;
    end else begin
      if (cmd_i.start) begin
        ph_head_q <= ph_next;
        prd_ptr_q <= ph_next;
      end else if (cmd_i.fin_fast) begin
        prd_ptr_q <= ph_head_q;
      end else if (cmd_i.issue && cmd_i.win != WIN_SIG) begin
        prd_ptr_q <= (prd_ptr_q == '0) ? PH_W'(HIST_DEPTH - 1) : prd_ptr_q - PH_W'(1);
      end
      if (cmd_i.fin_slow) begin
        mh_head_q <= mh_next;
        mrd_ptr_q <= mh_next;
      end else if (cmd_i.issue && cmd_i.win == WIN_SIG) begin
        mrd_ptr_q <= (mrd_ptr_q == '0) ? MH_W'(SIGNAL_TAPS - 1) : mrd_ptr_q - MH_W'(1);
      end
    end
  end

  // multiply-accumulate pipeline: read, multiply, accumulate
  assign mul_a  = (win1_q == WIN_SIG) ? {macd_rd_q[DATA_W-1], macd_rd_q}
                                      : $signed(MUL_A_W'(price_rd_q));
  assign mul_b  = $signed({1'b0, w1_q});
  assign prod_d = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    w1_q   <= weight_d;
    win1_q <= cmd_i.win;
    prod_q <= prod_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      if (cmd_i.acc_clr) begin
        acc_q <= '0;
      end else if (v2_q) begin
        acc_q <= acc_q + ACC_W'(prod_q);
      end
    end
  end

  assign acc_rnd  = acc_q + $signed(RND_HALF);
  assign avg_d    = $signed(acc_rnd[ACC_W-1:W_FRAC]);
  assign diff_d   = {fast_avg_q[AVG_W-1], fast_avg_q} - {avg_d[AVG_W-1], avg_d};
  assign macd_sat = sat_data(diff_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin_fast) begin
      fast_avg_q <= avg_d;
    end
    if (cmd_i.fin_slow) begin
      macd_q <= macd_sat;
    end
    if (cmd_i.fin_sig) begin
      sig_q       <= cmd_i.sig_valid ? sat_data({avg_d[AVG_W-1], avg_d}) : '0;
      sig_valid_q <= cmd_i.sig_valid;
    end
  end

  always_comb begin
    if (prev_sig_q > prev_macd_q && sig_q < macd_q) begin
      event_d = EV_BUY;
    end else if (prev_sig_q < prev_macd_q && sig_q > macd_q) begin
      event_d = EV_SELL;
    end else begin
      event_d = EV_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_macd_q <= '0;
      prev_sig_q  <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cmd_i.out_load) begin
        prev_macd_q <= macd_q;
        prev_sig_q  <= sig_q;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      macd_o         <= macd_q;
      signal_o       <= sig_q;
      signal_valid_o <= sig_valid_q;
      event_q        <= event_d;
    end
  end

  assign event_o           = event_q;
  assign status_o.busy     = v1_q | v2_q;
  assign status_o.out_free = !out_valid_o | out_ready_i;

endmodule
